FILE: hdl/pbf_pkg.sv
// Package for the plane basis block: widths, state codes and small helpers.
// Used by every module in hdl; depends on nothing.
package pbf_pkg;

  localparam int FRAC_BITS = 12;
  localparam int IN_W      = 25;
  localparam int OUT_W     = 14;
  // Cross products of unit vectors reach 2 * ONE * ONE; the normal input fits too.
  localparam int VEC_W     = 2 * FRAC_BITS + 3;
  localparam int SUM_W     = 2 * VEC_W;
  localparam int ROOT_W    = VEC_W;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int DCNT_W    = $clog2(QUO_W + 1);
  localparam int SCNT_W    = $clog2(ROOT_W + 1);

  typedef logic signed [VEC_W-1:0] vec_comp_t;
  typedef logic signed [OUT_W-1:0] out_comp_t;

  localparam out_comp_t ONE = out_comp_t'(1 << FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_AXIS,
    ST_CROSS_GO,
    ST_CROSS_WAIT,
    ST_FIN
  } pbf_state_e;

  function automatic logic [VEC_W-1:0] mag_vec(input vec_comp_t x);
    mag_vec = x[VEC_W-1] ? VEC_W'(-x) : VEC_W'(x);
  endfunction

  function automatic logic [OUT_W-1:0] mag_out(input out_comp_t x);
    mag_out = x[OUT_W-1] ? OUT_W'(-x) : OUT_W'(x);
  endfunction

  // Operand of n for term t of n x u; two terms per component, the second subtracted.
  function automatic logic [1:0] cross_a_idx(input logic [2:0] t);
    unique case (t)
      3'd0:    cross_a_idx = 2'd1;
      3'd1:    cross_a_idx = 2'd2;
      3'd2:    cross_a_idx = 2'd2;
      3'd3:    cross_a_idx = 2'd0;
      3'd4:    cross_a_idx = 2'd0;
      3'd5:    cross_a_idx = 2'd1;
      default: cross_a_idx = 2'd0;
    endcase
  endfunction

  // Operand of u for term t of n x u.
  function automatic logic [1:0] cross_b_idx(input logic [2:0] t);
    unique case (t)
      3'd0:    cross_b_idx = 2'd2;
      3'd1:    cross_b_idx = 2'd1;
      3'd2:    cross_b_idx = 2'd0;
      3'd3:    cross_b_idx = 2'd2;
      3'd4:    cross_b_idx = 2'd1;
      3'd5:    cross_b_idx = 2'd0;
      default: cross_b_idx = 2'd0;
    endcase
  endfunction

endpackage

FILE: hdl/plane_basis_from_normal.sv
// Top level of the plane basis block: sequencer, vector registers and output stage.
// Depends on pbf_pkg, pbf_mul, pbf_sqrt and pbf_div.
//
// Usage: a transaction on the input channel carries a signed integer normal
// (normal_x_i, normal_y_i, normal_z_i). It is taken when in_valid_i is high
// and in_stall_o is low. The block then works on that one transaction alone
// and answers one result transaction: the unit normal n, the in-plane axes
// u and v in 1.12 fixed point, and the degenerate flag for a zero normal,
// in which case the XY plane is returned.
// Each of up to three normalisations squares three components on a bit-serial
// multiplier (one multiplier bit per cycle, ending early on small values),
// takes a floor square root at one root bit per cycle and runs three
// divisions at one quotient bit per cycle. Between the second and third
// normalisation, n x u is formed on the same multiplier as six products.
// A zero normal is answered after the first normalisation; any other normal
// takes longer, and its run time grows with the operand magnitudes.
// The result sits in an output register: in_stall_o drops as soon as it is
// loaded, so the next transaction may start while the receiver stalls; the
// block only waits at its end if the earlier result is still not taken.
// Reset clears the sequencer and the output valid; no result is pending.
module plane_basis_from_normal import pbf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [IN_W-1:0] normal_x_i,
  input  logic signed [IN_W-1:0] normal_y_i,
  input  logic signed [IN_W-1:0] normal_z_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [OUT_W-1:0] unit_nx_o,
  output logic signed [OUT_W-1:0] unit_ny_o,
  output logic signed [OUT_W-1:0] unit_nz_o,
  output logic signed [OUT_W-1:0] axis_ux_o,
  output logic signed [OUT_W-1:0] axis_uy_o,
  output logic signed [OUT_W-1:0] axis_uz_o,
  output logic signed [OUT_W-1:0] axis_vx_o,
  output logic signed [OUT_W-1:0] axis_vy_o,
  output logic signed [OUT_W-1:0] axis_vz_o,
  output logic                  degenerate_o
);

  pbf_state_e state_q, state_d;
  logic [1:0] pass_q, pass_d;   // 0: normal, 1: u, 2: v
  logic [2:0] idx_q, idx_d;     // component, or product term in the cross step
  vec_comp_t  w_q [3];
  vec_comp_t  w_d [3];
  out_comp_t  n_q [3];
  out_comp_t  n_d [3];
  out_comp_t  u_q [3];
  out_comp_t  u_d [3];
  out_comp_t  v_q [3];
  out_comp_t  v_d [3];
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [ROOT_W-1:0] len_q, len_d;
  logic              deg_q, deg_d;

  logic      out_valid_q, out_valid_d;
  out_comp_t out_n_q [3];
  out_comp_t out_n_d [3];
  out_comp_t out_u_q [3];
  out_comp_t out_u_d [3];
  out_comp_t out_v_q [3];
  out_comp_t out_v_d [3];
  logic      out_deg_q, out_deg_d;

  logic              mul_start, mul_busy, mul_done;
  logic [SUM_W-1:0]  mul_a, mul_prod;
  logic [VEC_W-1:0]  mul_b;
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic              div_start, div_done;
  logic [QUO_W-1:0]  div_quo;

  logic [OUT_W-1:0]  mx, my, mz;
  logic [1:0]        ai, bi, ci;
  out_comp_t         quo_s;
  vec_comp_t         term;
  logic              term_neg;

  pbf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  pbf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sum_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  pbf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag_vec(w_q[idx_q[1:0]])),
    .den_i   (len_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    ai = cross_a_idx(idx_q);
    bi = cross_b_idx(idx_q);
    ci = idx_q[2:1];
    if (state_q == ST_CROSS_GO) begin
      mul_a = SUM_W'(mag_out(n_q[ai]));
      mul_b = VEC_W'(mag_out(u_q[bi]));
    end else begin
      mul_a = SUM_W'(mag_vec(w_q[idx_q[1:0]]));
      mul_b = mag_vec(w_q[idx_q[1:0]]);
    end
    mx = mag_out(n_q[0]);
    my = mag_out(n_q[1]);
    mz = mag_out(n_q[2]);
    // Signed quotient; a zero length only occurs for the zero vector.
    quo_s = (len_q == '0) ? '0 : out_comp_t'(div_quo);
    if (w_q[idx_q[1:0]][VEC_W-1]) begin
      quo_s = -quo_s;
    end
    term     = $signed(mul_prod[VEC_W-1:0]);
    term_neg = n_q[ai][OUT_W-1] ^ u_q[bi][OUT_W-1] ^ idx_q[0];
    if (term_neg) begin
      term = -term;
    end
  end

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    idx_d       = idx_q;
    w_d         = w_q;
    n_d         = n_q;
    u_d         = u_q;
    v_d         = v_q;
    sum_d       = sum_q;
    len_d       = len_q;
    deg_d       = deg_q;
    out_n_d     = out_n_q;
    out_u_d     = out_u_q;
    out_v_d     = out_v_q;
    out_deg_d   = out_deg_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_start   = 1'b0;
    sqrt_start  = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          w_d[0]  = vec_comp_t'(normal_x_i);
          w_d[1]  = vec_comp_t'(normal_y_i);
          w_d[2]  = vec_comp_t'(normal_z_i);
          pass_d  = 2'd0;
          idx_d   = '0;
          sum_d   = '0;
          deg_d   = 1'b0;
          state_d = ST_SQ_GO;
        end
      end
      ST_SQ_GO: begin
        mul_start = 1'b1;
        state_d   = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mul_done) begin
          sum_d = sum_q + mul_prod;
          if (idx_q == 3'd2) begin
            state_d = ST_ROOT_GO;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_SQ_GO;
          end
        end
      end
      ST_ROOT_GO: begin
        sqrt_start = 1'b1;
        state_d    = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sqrt_done) begin
          len_d   = sqrt_root;
          idx_d   = '0;
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          unique case (pass_q)
            2'd0:    n_d[idx_q[1:0]] = quo_s;
            2'd1:    u_d[idx_q[1:0]] = quo_s;
            default: v_d[idx_q[1:0]] = quo_s;
          endcase
          if (idx_q != 3'd2) begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_DIV_GO;
          end else begin
            idx_d = '0;
            sum_d = '0;
            unique case (pass_q)
              2'd0:    state_d = ST_AXIS;
              2'd1:    state_d = ST_CROSS_GO;
              default: state_d = ST_FIN;
            endcase
          end
        end
      end
      ST_AXIS: begin
        if (n_q[0] == '0 && n_q[1] == '0 && n_q[2] == '0) begin
          // Zero normal: fall back to the XY plane.
          n_d     = '{'0, '0, ONE};
          u_d     = '{ONE, '0, '0};
          v_d     = '{'0, ONE, '0};
          deg_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          priority if (mx <= my && mx <= mz) begin
            w_d = '{'0, -(vec_comp_t'(n_q[2]) <<< FRAC_BITS),
                    vec_comp_t'(n_q[1]) <<< FRAC_BITS};
          end else if (mx <= my || my > mz) begin
            w_d = '{-(vec_comp_t'(n_q[1]) <<< FRAC_BITS),
                    vec_comp_t'(n_q[0]) <<< FRAC_BITS, '0};
          end else begin
            w_d = '{vec_comp_t'(n_q[2]) <<< FRAC_BITS, '0,
                    -(vec_comp_t'(n_q[0]) <<< FRAC_BITS)};
          end
          pass_d  = 2'd1;
          state_d = ST_SQ_GO;
        end
      end
      ST_CROSS_GO: begin
        mul_start = 1'b1;
        state_d   = ST_CROSS_WAIT;
      end
      ST_CROSS_WAIT: begin
        if (mul_done) begin
          w_d[ci] = idx_q[0] ? w_q[ci] + term : term;
          if (idx_q == 3'd5) begin
            idx_d   = '0;
            pass_d  = 2'd2;
            state_d = ST_SQ_GO;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_CROSS_GO;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_n_d     = n_q;
          out_u_d     = u_q;
          out_v_d     = v_q;
          out_deg_d   = deg_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q    <= pass_d;
    idx_q     <= idx_d;
    w_q       <= w_d;
    n_q       <= n_d;
    u_q       <= u_d;
    v_q       <= v_d;
    sum_q     <= sum_d;
    len_q     <= len_d;
    deg_q     <= deg_d;
    out_n_q   <= out_n_d;
    out_u_q   <= out_u_d;
    out_v_q   <= out_v_d;
    out_deg_q <= out_deg_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign unit_nx_o    = out_n_q[0];
  assign unit_ny_o    = out_n_q[1];
  assign unit_nz_o    = out_n_q[2];
  assign axis_ux_o    = out_u_q[0];
  assign axis_uy_o    = out_u_q[1];
  assign axis_uz_o    = out_u_q[2];
  assign axis_vx_o    = out_v_q[0];
  assign axis_vy_o    = out_v_q[1];
  assign axis_vz_o    = out_v_q[2];
  assign degenerate_o = out_deg_q;

  // The shared multiplier is never restarted while it is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");

  // A quotient never exceeds one in fixed point, since no component exceeds the length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done && len_q != '0 |-> div_quo <= QUO_W'(1 << FRAC_BITS))
    else $error("quotient above one");

  // A degenerate result always carries the fallback normal along z.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_deg_q |-> out_n_q[2] == ONE && out_n_q[0] == '0)
    else $error("degenerate result without fallback normal");

endmodule

FILE: hdl/pbf_mul.sv
// Bit-serial shift-and-add multiplier on unsigned magnitudes.
// Depends on pbf_pkg; finishes as soon as the remaining multiplier bits are zero.
module pbf_mul import pbf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] a_i,
  input  logic [VEC_W-1:0] b_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [SUM_W-1:0] prod_o
);

  logic             run_q, done_q;
  logic [SUM_W-1:0] a_q, acc_q;
  logic [VEC_W-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && b_q == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[SUM_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[VEC_W-1:1]};
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: hdl/pbf_sqrt.sv
// Restoring floor square root, two radicand bits and one root bit per cycle.
// Depends on pbf_pkg.
module pbf_sqrt import pbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              run_q, done_q;
  logic [SCNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]  rad_q;
  logic [ROOT_W:0]   rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W+2:0] rem_sh, trial;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q, rad_q[SUM_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SCNT_W'(ROOT_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
      rem_q  <= ge ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hdl/pbf_div.sv
// Restoring divider giving floor(num * 2^FRAC_BITS / den), one quotient bit per cycle.
// Depends on pbf_pkg; expects num no larger than den.
module pbf_div import pbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [VEC_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic              done_o,
  output logic [QUO_W-1:0]  quo_o
);

  logic              run_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [ROOT_W:0]   rem_q, rem_sub;
  logic [ROOT_W-1:0] den_q;
  logic [QUO_W-1:0]  quo_q;
  logic              ge;

  always_comb begin
    ge      = rem_q >= {1'b0, den_q};
    rem_sub = ge ? rem_q - {1'b0, den_q} : rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(QUO_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= {rem_sub[ROOT_W-1:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
